### rtl/core/msc_pkg.sv
// Shared constants, types and helpers for the majority subarray counter.
// Depends on nothing; every other file of the block but msc_ram uses it.
`timescale 1ns / 1ps

package msc_pkg;

   localparam int MAX_LEN    = 1024;
   localparam int DATA_W     = 32;
   localparam int LEN_W      = $clog2(MAX_LEN + 1);
   localparam int BAL_W      = LEN_W + 1;
   localparam int HIST_DEPTH = 2 * MAX_LEN + 1;
   localparam int ADDR_W     = $clog2(HIST_DEPTH);
   localparam int CNT_W      = $clog2(MAX_LEN + 2);
   localparam int END_W      = 11;
   localparam int TOTAL_W    = 20;
   localparam int SUM_W      = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 2;
   localparam int OUTQ_DEPTH = 3;
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   typedef logic signed [BAL_W-1:0] bal_type;
   typedef logic [CNT_W-1:0]        hist_type;
   typedef logic [ADDR_W-1:0]       addr_type;

   // Where the histogram value of a read port comes from in the update stage
   typedef enum logic [1:0] {
      SRC_MEM,
      SRC_FWD,
      SRC_ZERO,
      SRC_ONE
   } src_type;

   typedef struct packed {
      logic     valid;
      logic     first;
      logic     ovf;
      logic     match;
      src_type  src_a;
      src_type  src_b;
      addr_type waddr;
      hist_type fwd_data;
   } issue_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      hist_type data;
   } wr_type;

   typedef struct packed {
      logic [END_W-1:0]   ending_here;
      logic [TOTAL_W-1:0] total_so_far;
      logic               overflow;
   } result_type;

   // Balance in [-MAX_LEN, MAX_LEN] maps to histogram row balance + MAX_LEN
   function automatic addr_type hist_addr(bal_type bal);
      logic signed [BAL_W:0] wide;
      wide = {bal[BAL_W-1], bal} + (BAL_W + 1)'(MAX_LEN);
      return wide[ADDR_W-1:0];
   endfunction

endpackage

### rtl/core/msc_req_if.sv
// Input channel of the majority subarray counter: valid, ready, one element and a first flag.
// Depends on msc_pkg for the field widths.
`timescale 1ns / 1ps

interface msc_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [msc_pkg::DATA_W-1:0] element;
   logic                              first;

   modport source (output valid, output element, output first, input ready);
   modport sink (input valid, input element, input first, output ready);
endinterface

### rtl/core/msc_rsp_if.sv
// Result channel of the majority subarray counter: valid, ready and one result.
// Depends on msc_pkg for the field widths.
`timescale 1ns / 1ps

interface msc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [msc_pkg::END_W-1:0]    ending_here;
   logic [msc_pkg::TOTAL_W-1:0]  total_so_far;
   logic                         overflow;

   modport source (output valid, output ending_here, output total_so_far,
                   output overflow, input ready);
   modport sink (input valid, input ending_here, input total_so_far,
                 input overflow, output ready);
endinterface

### rtl/core/msc_ram.sv
// Generic single-write, dual-read synchronous RAM with registered read data.
// Read returns the old contents when read and write hit the same row.
`timescale 1ns / 1ps

module msc_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

### rtl/core/msc_issue.sv
// Issue stage: tracks balance, visited balance range and length, issues the
// histogram reads and decides per port between RAM, forwarded or initial data.
`timescale 1ns / 1ps

module msc_issue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic signed [msc_pkg::DATA_W-1:0] element,
   input  logic                              first,
   input  logic signed [msc_pkg::DATA_W-1:0] target,
   input  msc_pkg::wr_type                   wr,
   output msc_pkg::addr_type                 rd_addr_a,
   output msc_pkg::addr_type                 rd_addr_b,
   output msc_pkg::issue_type                iss
);
   import msc_pkg::*;

   bal_type          bal_ff, bal_in;
   bal_type          lo_ff, lo_in;
   bal_type          hi_ff, hi_in;
   logic             zw_ff, zw_in;
   logic [LEN_W-1:0] len_ff, len_in;
   issue_type        iss_ff, iss_in;

   bal_type          bal_base, lo_base, hi_base, bal_new, bal_a;
   logic             zw_base, ovf, match, hit_a, hit_b;
   logic [LEN_W-1:0] len_base;

   // Rows inside the visited range were written this sequence; others hold
   // their restart value. Row for balance zero starts at one until written.
   function automatic src_type pick_src(bal_type b, bal_type lo, bal_type hi,
                                        logic zw, logic hit);
      src_type s;
      if (b == bal_type'(0)) begin
         s = zw ? (hit ? SRC_FWD : SRC_MEM) : SRC_ONE;
      end else if (b >= lo && b <= hi) begin
         s = hit ? SRC_FWD : SRC_MEM;
      end else begin
         s = SRC_ZERO;
      end
      return s;
   endfunction

   always_comb begin
      bal_base = first ? bal_type'(0) : bal_ff;
      lo_base  = first ? bal_type'(0) : lo_ff;
      hi_base  = first ? bal_type'(0) : hi_ff;
      zw_base  = first ? 1'b0 : zw_ff;
      len_base = first ? '0 : len_ff;

      ovf     = len_base >= LEN_W'(MAX_LEN);
      match   = element == target;
      bal_new = match ? bal_base + bal_type'(1) : bal_base - bal_type'(1);
      bal_a   = match ? bal_base : bal_new;

      rd_addr_a = hist_addr(bal_a);
      rd_addr_b = hist_addr(bal_new);

      // The item now in update writes its row this cycle; the RAM read misses it
      hit_a = wr.en && (wr.addr == rd_addr_a);
      hit_b = wr.en && (wr.addr == rd_addr_b);

      iss_in.valid    = accept;
      iss_in.first    = first;
      iss_in.ovf      = ovf;
      iss_in.match    = match;
      iss_in.src_a    = pick_src(bal_a, lo_base, hi_base, zw_base, hit_a);
      iss_in.src_b    = pick_src(bal_new, lo_base, hi_base, zw_base, hit_b);
      iss_in.waddr    = rd_addr_b;
      iss_in.fwd_data = wr.data;

      bal_in = bal_ff;
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      zw_in  = zw_ff;
      len_in = len_ff;
      if (accept && !ovf) begin
         bal_in = bal_new;
         lo_in  = (bal_new < lo_base) ? bal_new : lo_base;
         hi_in  = (bal_new > hi_base) ? bal_new : hi_base;
         zw_in  = zw_base || (bal_new == bal_type'(0));
         len_in = len_base + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bal_ff <= '0;
         lo_ff  <= '0;
         hi_ff  <= '0;
         zw_ff  <= 1'b0;
         len_ff <= '0;
         iss_ff <= '0;
      end else begin
         bal_ff <= bal_in;
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         zw_ff  <= zw_in;
         len_ff <= len_in;
         iss_ff <= iss_in;
      end
   end

   assign iss = iss_ff;

endmodule

### rtl/core/msc_update.sv
// Update stage: combines histogram read data into the ending count and
// running total, and writes the incremented histogram row back.
`timescale 1ns / 1ps

module msc_update (
   input  logic                 clock,
   input  logic                 reset,
   input  msc_pkg::issue_type   iss,
   input  msc_pkg::hist_type    rd_data_a,
   input  msc_pkg::hist_type    rd_data_b,
   output msc_pkg::wr_type      wr,
   output logic                 push,
   output msc_pkg::result_type  result
);
   import msc_pkg::*;

   logic [LEN_W-1:0]   end_ff, end_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   hist_type                hist_a, hist_b;
   logic [LEN_W-1:0]        end_base, end_new;
   logic [TOTAL_W-1:0]      total_base, total_new;
   logic signed [SUM_W-1:0] base_s, sum_s;

   function automatic hist_type pick(src_type s, hist_type fwd, hist_type mem);
      hist_type v;
      unique case (s)
         SRC_MEM:  v = mem;
         SRC_FWD:  v = fwd;
         SRC_ZERO: v = '0;
         SRC_ONE:  v = hist_type'(1);
      endcase
      return v;
   endfunction

   always_comb begin
      hist_a     = pick(iss.src_a, iss.fwd_data, rd_data_a);
      hist_b     = pick(iss.src_b, iss.fwd_data, rd_data_b);
      end_base   = iss.first ? '0 : end_ff;
      total_base = iss.first ? '0 : total_ff;

      base_s = SUM_W'(end_base);
      sum_s  = iss.match ? base_s + SUM_W'(hist_a) : base_s - SUM_W'(hist_b);
      // clamp at zero
      end_new   = sum_s[SUM_W-1] ? '0 : LEN_W'(sum_s);
      total_new = total_base + TOTAL_W'(end_new);

      wr.en   = iss.valid && !iss.ovf;
      wr.addr = iss.waddr;
      wr.data = hist_b + hist_type'(1);

      push = iss.valid;
      if (iss.ovf) begin
         result.ending_here  = '0;
         result.total_so_far = total_base;
         result.overflow     = 1'b1;
      end else begin
         result.ending_here  = END_W'(end_new);
         result.total_so_far = total_new;
         result.overflow     = 1'b0;
      end

      end_in   = end_ff;
      total_in = total_ff;
      if (wr.en) begin
         end_in   = end_new;
         total_in = total_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_ff   <= '0;
         total_ff <= '0;
      end else begin
         end_ff   <= end_in;
         total_ff <= total_in;
      end
   end

endmodule

### rtl/core/msc_out_queue.sv
// Result queue of OUTQ_DEPTH entries between the update stage and the result
// channel; the fill count feeds the input credit check. Depends on msc_pkg.
`timescale 1ns / 1ps

module msc_out_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  msc_pkg::result_type             push_data,
   msc_rsp_if.source                       rsp_chan,
   output logic [msc_pkg::OUTQ_CNT_W-1:0]  count
);
   import msc_pkg::*;

   localparam int PTR_W = $clog2(OUTQ_DEPTH);

   result_type            slot_ff [OUTQ_DEPTH];
   logic [PTR_W-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [OUTQ_CNT_W-1:0] count_ff, count_in;
   logic                  pop;
   result_type            head_data;

   function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
      return (p == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      pop       = rsp_chan.valid && rsp_chan.ready;
      head_in   = pop ? next_ptr(head_ff) : head_ff;
      tail_in   = push ? next_ptr(tail_ff) : tail_ff;
      count_in  = count_ff + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
      head_data = slot_ff[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

   assign rsp_chan.valid        = count_ff != '0;
   assign rsp_chan.ending_here  = head_data.ending_here;
   assign rsp_chan.total_so_far = head_data.total_so_far;
   assign rsp_chan.overflow     = head_data.overflow;
   assign count                 = count_ff;

endmodule

### rtl/core/majority_subarray_counter_unit.sv
// Majority subarray counter: one result per element, passed through the issue
// register and the result queue before it is offered; one element per cycle
// while the result queue has room, set by the histogram RAM (two reads and one
// write per element, read-modify-write forwarded).
// Synchronous active-high reset clears control state and the target value;
// the histogram RAM is not swept, rows outside the visited balance range read
// as their restart value, so the block is ready the cycle after reset.
`timescale 1ns / 1ps

module majority_subarray_counter_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic signed [msc_pkg::DATA_W-1:0] csr_wr_data,
   msc_req_if.sink                           req_chan,
   msc_rsp_if.source                         rsp_chan
);
   import msc_pkg::*;

   logic signed [DATA_W-1:0] target_ff, target_in;
   logic                     accept;
   logic [OUTQ_CNT_W:0]      occupancy;
   logic [OUTQ_CNT_W-1:0]    q_count;
   addr_type                 rd_addr_a, rd_addr_b;
   hist_type                 rd_data_a, rd_data_b;
   issue_type                iss;
   wr_type                   wr;
   logic                     push;
   result_type               result;

   assign target_in = csr_wr_en ? csr_wr_data : target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

   // Hold off a transfer unless the queue has room for everything in flight
   assign occupancy      = {1'b0, q_count} + (OUTQ_CNT_W + 1)'(iss.valid);
   assign req_chan.ready = !reset && (occupancy < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
   assign accept         = req_chan.valid && req_chan.ready;

   msc_issue u_issue (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .element   (req_chan.element),
      .first     (req_chan.first),
      .target    (target_ff),
      .wr        (wr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .iss       (iss)
   );

   msc_ram #(
      .WIDTH (CNT_W),
      .DEPTH (HIST_DEPTH)
   ) u_hist_ram (
      .clock     (clock),
      .wr_en     (wr.en),
      .wr_addr   (wr.addr),
      .wr_data   (wr.data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   msc_update u_update (
      .clock     (clock),
      .reset     (reset),
      .iss       (iss),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr        (wr),
      .push      (push),
      .result    (result)
   );

   msc_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .rsp_chan  (rsp_chan),
      .count     (q_count)
   );

   a_no_queue_overrun: assert property (@(posedge clock) disable iff (reset)
      occupancy <= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH))
      else $error("result queue credit exceeded");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_chan.valid)
      else $error("no result two cycles after transfer");

   a_overflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.overflow) |-> (rsp_chan.ending_here == '0))
      else $error("overflow result carries a nonzero ending count");

endmodule

### verif/majority_subarray_counter_unit_tb.sv
// Testbench for majority_subarray_counter_unit: directed and random element streams,
// predicted per transfer and checked in order against every result transfer.
// Depends on msc_pkg, msc_req_if and msc_rsp_if from the RTL.
`timescale 1ns / 1ps

module majority_subarray_counter_unit_tb;

   localparam int MAX_LEN = msc_pkg::MAX_LEN;

   logic                              clock;
   logic                              reset;
   logic                              csr_wr_en;
   logic signed [msc_pkg::DATA_W-1:0] csr_wr_data;

   msc_req_if req_bus ();
   msc_rsp_if rsp_bus ();

   majority_subarray_counter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   // Predictor state: one sequence plus the current target value
   logic signed [msc_pkg::DATA_W-1:0] target_q;
   int          balance_hist [msc_pkg::HIST_DEPTH];
   int          seq_balance;
   int          seq_ending;
   int unsigned seq_total;
   int          seq_length;

   msc_pkg::result_type expected_counts [$];
   int                  mismatch_count;
   int                  send_idle_pct;
   int                  recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic void restart_counts();
      foreach (balance_hist[i]) balance_hist[i] = 0;
      balance_hist[MAX_LEN] = 1;
      seq_balance = 0;
      seq_ending  = 0;
      seq_total   = 0;
      seq_length  = 0;
   endfunction

   function automatic msc_pkg::result_type count_majority(
      input logic signed [msc_pkg::DATA_W-1:0] elem, input logic first_flag);
      msc_pkg::result_type res;
      if (first_flag) restart_counts();
      if (seq_length >= MAX_LEN) begin
         res.ending_here  = '0;
         res.total_so_far = msc_pkg::TOTAL_W'(seq_total);
         res.overflow     = 1'b1;
         return res;
      end
      if (elem == target_q) begin
         seq_ending += balance_hist[seq_balance + MAX_LEN];
         seq_balance++;
      end else begin
         seq_balance--;
         seq_ending -= balance_hist[seq_balance + MAX_LEN];
      end
      if (seq_ending < 0) seq_ending = 0;
      seq_total += seq_ending;
      balance_hist[seq_balance + MAX_LEN]++;
      seq_length++;
      res.ending_here  = msc_pkg::END_W'(seq_ending);
      res.total_so_far = msc_pkg::TOTAL_W'(seq_total);
      res.overflow     = 1'b0;
      return res;
   endfunction

   // Result receiver: stall at random
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each result transfer with the oldest expectation
   initial begin
      msc_pkg::result_type exp_res;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_counts.size() == 0) begin
               $error("result with none expected: ending_here %0d total_so_far %0d",
                      rsp_bus.ending_here, rsp_bus.total_so_far);
               mismatch_count++;
            end else begin
               exp_res = expected_counts.pop_front();
               if (rsp_bus.ending_here !== exp_res.ending_here) begin
                  $error("ending_here: expected %0d, got %0d",
                         exp_res.ending_here, rsp_bus.ending_here);
                  mismatch_count++;
               end
               if (rsp_bus.total_so_far !== exp_res.total_so_far) begin
                  $error("total_so_far: expected %0d, got %0d",
                         exp_res.total_so_far, rsp_bus.total_so_far);
                  mismatch_count++;
               end
               if (rsp_bus.overflow !== exp_res.overflow) begin
                  $error("overflow: expected %0d, got %0d",
                         exp_res.overflow, rsp_bus.overflow);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input logic signed [msc_pkg::DATA_W-1:0] elem,
                            input logic first_flag);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid   <= 1'b1;
      req_bus.element <= elem;
      req_bus.first   <= first_flag;
      do @(posedge clock); while (!req_bus.ready);
      expected_counts.push_back(count_majority(elem, first_flag));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (expected_counts.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_target(input logic signed [msc_pkg::DATA_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      target_q = value;
   endtask

   function automatic logic signed [msc_pkg::DATA_W-1:0] pick_element(input bit hit);
      if (hit) return target_q;
      case ($urandom_range(3))
         0:       return target_q ^ (32'sd1 << $urandom_range(31));
         1:       return $signed(32'($urandom_range(7))) - 32'sd3;
         default: return $urandom;
      endcase
   endfunction

   // No first flag since reset: the state is already a fresh sequence
   task automatic test_fresh_after_reset();
      send_item(32'sd0, 1'b0);
      send_item(32'sd0, 1'b0);
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sd0, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
   endtask

   // Extreme targets, elements one bit away, restarts in mid-sequence
   task automatic test_target_extremes();
      write_target(32'sh7FFF_FFFF);
      send_item(32'sh7FFF_FFFF, 1'b1);
      send_item(32'sh7FFF_FFFE, 1'b0);
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'shFFFF_FFFF, 1'b0);
      send_item(32'sh7FFF_FFFF, 1'b0);
      write_target(32'sh8000_0000);
      send_item(32'sh8000_0000, 1'b1);
      send_item(32'sd0, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh8000_0001, 1'b0);
      send_item(32'sh8000_0000, 1'b1);
      send_item(32'sh8000_0000, 1'b0);
      write_target(-32'sd1);
      send_item(32'sh7FFF_FFFF, 1'b1);
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(-32'sd1, 1'b0);
   endtask

   // Mostly well-formed sequences with random match density; some continue
   // the previous sequence and a few carry a stray restart
   task automatic test_random_sequences(input int n_items);
      int sent;
      int run_len;
      int hit_pct;
      bit broken;
      sent = 0;
      while (sent < n_items) begin
         run_len = ($urandom_range(15) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 30);
         hit_pct = $urandom_range(100);
         broken  = ($urandom_range(9) == 0);
         for (int i = 0; i < run_len && sent < n_items; i++) begin
            send_item(pick_element($urandom_range(99) < hit_pct),
                      (i == 0 && !broken) || $urandom_range(49) == 0);
            sent++;
         end
      end
   endtask

   // All-match sequence hits the largest counts, then runs past MAX_LEN
   task automatic test_sequence_overflow();
      send_item(target_q, 1'b1);
      for (int i = 1; i < MAX_LEN; i++) send_item(target_q, 1'b0);
      repeat (5) send_item(pick_element($urandom_range(1)), 1'b0);
      send_item(pick_element($urandom_range(1)), 1'b1);
      send_item(pick_element($urandom_range(1)), 1'b0);
   endtask

   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_bus.valid   = 1'b0;
      req_bus.element = '0;
      req_bus.first   = 1'b0;
      mismatch_count  = 0;
      send_idle_pct   = 37;
      recv_idle_pct   = 80;
      target_q        = '0;
      restart_counts();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_fresh_after_reset();
      test_target_extremes();
      write_target($urandom_range(3) - 1);
      test_random_sequences(200);

      write_target($urandom);
      send_idle_pct = 80;
      recv_idle_pct = 37;
      test_random_sequences(200);

      write_target(32'sd0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_sequence_overflow();
      write_target($urandom);
      test_random_sequences(200);

      wait_drained();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expected_counts.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/msc_pkg.sv
rtl/core/msc_req_if.sv
rtl/core/msc_rsp_if.sv
rtl/core/msc_ram.sv
rtl/core/msc_issue.sv
rtl/core/msc_update.sv
rtl/core/msc_out_queue.sv
rtl/core/majority_subarray_counter_unit.sv
verif/majority_subarray_counter_unit_tb.sv
